// ----- design/dpw_pkg.sv -----
// Shared types and constants of the DPW sawtooth oscillator.
package dpw_pkg;

  // Phase handed from the front end to the back end, reduced to 32 fraction bits.
  localparam int unsigned PHASE32_W = 32;
  // Signed width of the scaled difference: 33-bit difference times 32-bit gain.
  localparam int unsigned PROD_W = 65;
  // Entries of the queue between front and back end.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam logic REG_PHASE_STEP = 1'b0;
  localparam logic REG_GAIN       = 1'b1;

  // Register reset values.
  localparam logic [30:0] PHASE_STEP_RESET = 31'd42852281;
  localparam logic [31:0] GAIN_RESET       = 32'd1686236;

  // One tick request as it waits in the queue.
  typedef struct packed {
    logic [PHASE32_W-1:0] phase;
    logic                 clear;
  } dpw_tick_t;

endpackage

// ----- design/dpw_front.sv -----
// Front end: accepts tick requests, snapshots the phase and advances it.
module dpw_front #(
  parameter int unsigned PHASE_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_clear_extremes,
  input  logic [30:0]             phase_step,
  output logic                    q_push,
  output dpw_pkg::dpw_tick_t      q_wdata,
  input  logic                    q_full
);
  import dpw_pkg::*;

  logic [PHASE_BITS-1:0]           phase_acc_r;
  logic [PHASE_BITS-1:0]           phase_acc_nxt;
  logic [PHASE_BITS+PHASE32_W-1:0] step_wide;
  logic [PHASE_BITS+PHASE32_W-1:0] acc_wide;
  logic [PHASE_BITS-1:0]           step_aligned;

  // Align the Q0.32 step to the accumulator and the accumulator back to Q0.32.
  assign step_wide    = {1'b0, phase_step, {PHASE_BITS{1'b0}}};
  assign step_aligned = step_wide[PHASE_BITS+PHASE32_W-1 -: PHASE_BITS];
  assign acc_wide     = {phase_acc_r, {PHASE32_W{1'b0}}};

  assign in_ready        = !q_full;
  assign q_push          = in_valid && !q_full;
  assign q_wdata.phase   = acc_wide[PHASE_BITS+PHASE32_W-1 -: PHASE32_W];
  assign q_wdata.clear   = in_clear_extremes;
  assign phase_acc_nxt   = phase_acc_r + step_aligned;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
    end else if (q_push) begin
      phase_acc_r <= phase_acc_nxt;
    end
  end

endmodule

// ----- design/dpw_queue.sv -----
// Short queue of tick requests between front and back end.
module dpw_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dpw_pkg::dpw_tick_t wdata,
  output logic               full,
  input  logic               pop,
  output dpw_pkg::dpw_tick_t rdata,
  output logic               not_empty
);
  import dpw_pkg::*;

  dpw_tick_t              entry_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] count_r;
  logic                   do_push;
  logic                   do_pop;

  assign full      = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- design/dpw_back.sv -----
// Back end: square, central difference, gain, saturation and min/max tracking.
module dpw_back #(
  parameter int unsigned OUT_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_not_empty,
  input  dpw_pkg::dpw_tick_t         q_rdata,
  output logic                       q_pop,
  input  logic [31:0]                gain,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_BITS-1:0] out_sample,
  output logic signed [OUT_BITS-1:0] out_lowest,
  output logic signed [OUT_BITS-1:0] out_highest
);
  import dpw_pkg::*;

  localparam int unsigned OUT_SHIFT = 51 - OUT_BITS;
  localparam logic signed [PROD_W-1:0] SAT_MAX =
    (PROD_W'(1) <<< (OUT_BITS - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] SAT_MIN = -SAT_MAX - PROD_W'(1);
  localparam logic signed [OUT_BITS-1:0] OUT_MAX = SAT_MAX[OUT_BITS-1:0];
  localparam logic signed [OUT_BITS-1:0] OUT_MIN = SAT_MIN[OUT_BITS-1:0];

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DIFF,
    ST_MUL,
    ST_SCALE,
    ST_TRACK
  } back_state_t;

  back_state_t                state_r;
  logic [31:0]                x_mag_r;
  logic                       clear_r;
  logic [31:0]                sq_r;
  logic [31:0]                dly_one_r;
  logic [31:0]                dly_two_r;
  logic                       d_neg_r;
  logic [31:0]                d_mag_r;
  logic [63:0]                pmag_r;
  logic signed [OUT_BITS-1:0] smp_r;
  logic signed [OUT_BITS-1:0] min_r;
  logic signed [OUT_BITS-1:0] max_r;
  logic                       out_valid_r;
  logic signed [OUT_BITS-1:0] out_sample_r;

  logic [31:0]                x_mag_w;
  logic [63:0]                sq_full_w;
  logic [32:0]                diff_w;
  logic [32:0]                diff_neg_w;
  logic signed [PROD_W-1:0]   prod_w;
  logic signed [PROD_W-1:0]   shifted_w;
  logic signed [PROD_W-1:0]   sat_w;
  logic signed [OUT_BITS-1:0] min_base_w;
  logic signed [OUT_BITS-1:0] max_base_w;
  logic                       out_free_w;

  always_comb begin
    // |phase - 1/2| in Q0.32; exact up to one half.
    if (q_rdata.phase[31]) begin
      x_mag_w = {1'b0, q_rdata.phase[30:0]};
    end else begin
      x_mag_w = 32'h8000_0000 - q_rdata.phase;
    end
    sq_full_w  = x_mag_r * x_mag_r;
    diff_w     = {1'b0, sq_r} - {1'b0, dly_two_r};
    diff_neg_w = -diff_w;
    prod_w     = d_neg_r ? -$signed({1'b0, pmag_r}) : $signed({1'b0, pmag_r});
    // Arithmetic shift gives the floor.
    shifted_w  = prod_w >>> OUT_SHIFT;
    if (shifted_w > SAT_MAX) begin
      sat_w = SAT_MAX;
    end else if (shifted_w < SAT_MIN) begin
      sat_w = SAT_MIN;
    end else begin
      sat_w = shifted_w;
    end
    min_base_w = clear_r ? OUT_MAX : min_r;
    max_base_w = clear_r ? OUT_MIN : max_r;
    out_free_w = !out_valid_r || out_ready;
  end

  assign q_pop       = (state_r == ST_IDLE) && q_not_empty;
  assign out_valid   = out_valid_r;
  assign out_sample  = out_sample_r;
  assign out_lowest  = min_r;
  assign out_highest = max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      dly_one_r   <= '0;
      dly_two_r   <= '0;
      min_r       <= OUT_MAX;
      max_r       <= OUT_MIN;
    end else begin
      // Drop valid once taken, unless the next result loads in the same cycle.
      if (out_valid_r && out_ready && (state_r != ST_TRACK)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_not_empty) begin
            x_mag_r <= x_mag_w;
            clear_r <= q_rdata.clear;
            state_r <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          sq_r    <= sq_full_w[62:31];
          state_r <= ST_DIFF;
        end
        ST_DIFF: begin
          d_neg_r   <= diff_w[32];
          d_mag_r   <= diff_w[32] ? diff_neg_w[31:0] : diff_w[31:0];
          dly_two_r <= dly_one_r;
          dly_one_r <= sq_r;
          state_r   <= ST_MUL;
        end
        ST_MUL: begin
          pmag_r  <= d_mag_r * gain;
          state_r <= ST_SCALE;
        end
        ST_SCALE: begin
          smp_r   <= sat_w[OUT_BITS-1:0];
          state_r <= ST_TRACK;
        end
        ST_TRACK: begin
          // Hold until the output register is free.
          if (out_free_w) begin
            out_sample_r <= smp_r;
            min_r        <= (smp_r < min_base_w) ? smp_r : min_base_w;
            max_r        <= (smp_r > max_base_w) ? smp_r : max_base_w;
            out_valid_r  <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/dpw_sawtooth_oscillator.sv -----
// Top level of the order-2 DPW sawtooth oscillator with APB configuration.
//
// Every input request is one sample tick and yields exactly one result: a
// saturated signed Q2.(OUT_BITS-3) sawtooth sample plus the running minimum
// and maximum of all samples since reset or since the last request whose
// in_clear_extremes bit was set (the clear takes effect before that tick's
// sample is counted). The front end accepts a request, snapshots the phase and
// advances it by phase_step; a two-entry queue decouples it from the back-end
// sequencer, which squares 2*phase-1, forms half the difference to the square
// from two ticks earlier, scales it by gain (Q16.16), floors and saturates.
// The back end steps through its states in order for each request (pop, square,
// difference, gain multiply, scale/saturate, track/load output), with its two
// 32x32 multiplies in separate states, and holds in the last while the output
// register is full; it pops no new request until the last has loaded its output.
// in_ready stays high while the queue has room, also while a finished result
// waits in the output register. After reset the delay line is zero, so the
// first samples usually saturate. Registers: phase_step
// at byte address 0 (31 bits, Q0.32 cycles per tick), gain at byte address 4
// (32 bits, Q16.16); write them only while the block is idle.
module dpw_sawtooth_oscillator #(
  parameter int unsigned PHASE_BITS = 32,
  parameter int unsigned OUT_BITS   = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // Tick requests
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_clear_extremes,
  // Results
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_BITS-1:0] out_sample,
  output logic signed [OUT_BITS-1:0] out_lowest,
  output logic signed [OUT_BITS-1:0] out_highest
);
  import dpw_pkg::*;

  logic [30:0] phase_step_r;
  logic [31:0] gain_r;
  logic        cfg_write;

  dpw_tick_t   q_wdata;
  dpw_tick_t   q_rdata;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_not_empty;

  // Register write completes in the access phase; no wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= PHASE_STEP_RESET;
      gain_r       <= GAIN_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_PHASE_STEP: phase_step_r <= pwdata[30:0];
        REG_GAIN:       gain_r       <= pwdata;
        default:        gain_r       <= gain_r;
      endcase
    end
  end

  // Read back the addressed register; unused bits read as zero.
  always_comb begin
    case (paddr[2])
      REG_PHASE_STEP: prdata = {1'b0, phase_step_r};
      REG_GAIN:       prdata = gain_r;
      default:        prdata = '0;
    endcase
  end

  dpw_front #(
    .PHASE_BITS(PHASE_BITS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_clear_extremes (in_clear_extremes),
    .phase_step        (phase_step_r),
    .q_push            (q_push),
    .q_wdata           (q_wdata),
    .q_full            (q_full)
  );

  dpw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty)
  );

  dpw_back #(
    .OUT_BITS(OUT_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .gain        (gain_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_sample  (out_sample),
    .out_lowest  (out_lowest),
    .out_highest (out_highest)
  );

endmodule
